// ----- design/losw_pkg.sv -----
// ----------------------------------------------------------------------------
// losw_pkg
// Shared constants for the line-of-sight wall check block.
// ----------------------------------------------------------------------------
package losw_pkg;

  localparam int unsigned GRID_SIDE_BITS = 5;
  localparam int unsigned CELL_SIZE_BITS = 11;
  localparam logic [GRID_SIDE_BITS-1:0] GRID_SIDE_RESET = 5'd16;
  localparam logic [CELL_SIZE_BITS-1:0] CELL_SIZE_RESET = 11'd16;

  // Configuration register indexes.
  localparam logic CFG_GRID_SIDE = 1'b0;
  localparam logic CFG_CELL_SIZE = 1'b1;

  // Item kinds.
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

endpackage

// ----- design/line_of_sight_wall_check_core.sv -----
// ----------------------------------------------------------------------------
// line_of_sight_wall_check_core
// Maze wall map with a segment versus wall edge line-of-sight query.
// ----------------------------------------------------------------------------
// An item is transferred when start is high and busy is low. A load item
// (kind 0) writes one cell's wall code and gives no result; busy stays high
// through the S_LOAD state that follows the transfer, in which the wall memory is written.
// A query item (kind 1) walks the cells in index order. For each cell the
// wall code is read from memory, and each present edge is tested by a
// sequencer that runs the four orientation cross products through one shared
// multiplier, two products per orientation. A cell passes S_RD, S_WAIT and
// S_EDGE, each tested edge adds S_MUL and S_EVAL for every orientation and
// then S_EVAL2, and S_NEXT moves on. done rises through S_DONE after the
// last cell, or earlier at the first hit. The result can_see is shown for
// one cycle with done high, and busy is already low in that cycle. The
// receiver cannot stall the block.
// Reset (rst, synchronous) clears the control state, restores grid_side and
// cell_size, and then sweeps all MAX_SIDE*MAX_SIDE wall map entries to zero,
// one entry a cycle, while busy is high. Configuration writes (cfg_we,
// cfg_index, cfg_data) are taken in any cycle and should be made only while
// the block is idle.
// ----------------------------------------------------------------------------
module line_of_sight_wall_check_core #(
  parameter int MAX_SIDE   = 16,
  parameter int COORD_BITS = 14
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic                               kind,
  input  logic [7:0]                         cell_index,
  input  logic [1:0]                         wall_code,
  input  logic [COORD_BITS-1:0]              from_x,
  input  logic [COORD_BITS-1:0]              from_y,
  input  logic [COORD_BITS-1:0]              to_x,
  input  logic [COORD_BITS-1:0]              to_y,
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [losw_pkg::CELL_SIZE_BITS-1:0] cfg_data,
  output logic                               done,
  output logic                               can_see
);
  import losw_pkg::*;

  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = $clog2(MAX_SIDE + 1);
  localparam int CW    = $clog2(MAX_SIDE);
  // Edge coordinates stay below MAX_SIDE*2048; points stay below 2**COORD_BITS.
  localparam int EW0   = $clog2(MAX_SIDE * 1024 + 1) + 1;
  localparam int VW    = (EW0 > COORD_BITS + 1 ? EW0 : COORD_BITS + 1) + 1;
  localparam int PW    = 2 * VW;

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_LOAD  = 4'd2;
  localparam logic [3:0] S_RD    = 4'd3;
  localparam logic [3:0] S_WAIT  = 4'd4;
  localparam logic [3:0] S_EDGE  = 4'd5;
  localparam logic [3:0] S_MUL   = 4'd6;
  localparam logic [3:0] S_EVAL  = 4'd7;
  localparam logic [3:0] S_NEXT  = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;
  localparam logic [3:0] S_EVAL2 = 4'd10;

  logic [3:0] state;
  logic [GRID_SIDE_BITS-1:0] grid_side;
  logic [CELL_SIZE_BITS-1:0] cell_size;

  logic [1:0] wall_mem [DEPTH];
  logic [1:0] rd_data;
  logic [AW:0] addr;            // sweep / load / walk address
  logic [AW:0] ncells;
  logic [1:0] wcode_in;
  logic [CW-1:0] col;
  logic [SW-1:0] side;

  logic signed [VW-1:0] ax, ay, bx, by;
  logic signed [VW-1:0] x0, y0, cx, cy, dx, dy;
  logic [1:0] cur_w;
  logic       edge_top;
  logic [1:0] ostep;            // orientation 0..3
  logic       ohalf;            // first or second product
  logic signed [PW-1:0] prod, first_prod;
  logic [1:0] osgn [4];         // {neg, zero}

  logic signed [VW-1:0] mq_x, mq_y, mr_x, mr_y, ma, mb;
  logic hit;

  // Shared multiplier operand selection for orient(p, q, r).
  always_comb begin
    case (ostep)
      2'd0: begin mq_x = bx; mq_y = by; mr_x = cx; mr_y = cy; end
      2'd1: begin mq_x = bx; mq_y = by; mr_x = dx; mr_y = dy; end
      2'd2: begin mq_x = dx; mq_y = dy; mr_x = ax; mr_y = ay; end
      default: begin mq_x = dx; mq_y = dy; mr_x = bx; mr_y = by; end
    endcase
    if (ostep[1]) begin
      if (!ohalf) begin
        ma = mq_x - cx; mb = mr_y - cy;
      end else begin
        ma = mq_y - cy; mb = mr_x - cx;
      end
    end else begin
      if (!ohalf) begin
        ma = mq_x - ax; mb = mr_y - ay;
      end else begin
        ma = mq_y - ay; mb = mr_x - ax;
      end
    end
  end

  function automatic logic inbox(input logic signed [VW-1:0] px, py, qx, qy, rx, ry);
    logic okx, oky;
    begin
      okx = (px <= qx) ? (rx >= px && rx <= qx) : (rx >= qx && rx <= px);
      oky = (py <= qy) ? (ry >= py && ry <= qy) : (ry >= qy && ry <= py);
      return okx && oky;
    end
  endfunction

  // Sign arithmetic: o*o' < 0 means opposite nonzero signs.
  always_comb begin
    hit = ((osgn[0][0] == 1'b0 && osgn[1][0] == 1'b0 && osgn[0][1] != osgn[1][1]) &&
           (osgn[2][0] == 1'b0 && osgn[3][0] == 1'b0 && osgn[2][1] != osgn[3][1])) ||
          (osgn[0][0] && inbox(ax, ay, bx, by, cx, cy)) ||
          (osgn[1][0] && inbox(ax, ay, bx, by, dx, dy)) ||
          (osgn[2][0] && inbox(cx, cy, dx, dy, ax, ay)) ||
          (osgn[3][0] && inbox(cx, cy, dx, dy, bx, by));
  end

  assign busy = (state != S_IDLE);
  assign side = (grid_side > SW'(MAX_SIDE)) ? SW'(MAX_SIDE) : SW'(grid_side);

  always_ff @(posedge clk) begin
    rd_data <= wall_mem[addr[AW-1:0]];
    if ((state == S_CLR && addr < (AW+1)'(DEPTH)) || state == S_LOAD) begin
      wall_mem[addr[AW-1:0]] <= (state == S_CLR) ? 2'b00 : wcode_in;
    end
  end

  always_ff @(posedge clk) begin
    prod <= ma * mb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      addr      <= '0;
      done      <= 1'b0;
      can_see   <= 1'b1;
      grid_side <= GRID_SIDE_RESET;
      cell_size <= CELL_SIZE_RESET;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == CFG_GRID_SIDE) grid_side <= cfg_data[GRID_SIDE_BITS-1:0];
        else cell_size <= cfg_data;
      end
      case (state)
        S_CLR: begin
          if (addr >= (AW+1)'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
          addr <= addr + 1'b1;
        end
        S_IDLE: begin
          if (start) begin
            if (kind == KIND_LOAD) begin
              addr     <= (AW+1)'(cell_index);
              wcode_in <= wall_code;
              state    <= (32'(cell_index) < DEPTH) ? S_LOAD : S_IDLE;
            end else begin
              ax <= VW'(from_x); ay <= VW'(from_y);
              bx <= VW'(to_x);   by <= VW'(to_y);
              addr   <= '0;
              col    <= '0;
              x0     <= '0;
              y0     <= '0;
              ncells <= (AW+1)'(side * side);
              state  <= S_RD;
            end
          end
        end
        S_LOAD: state <= S_IDLE;
        S_RD: begin
          if (addr >= ncells) begin
            can_see <= 1'b1;
            state   <= S_DONE;
          end else begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          cur_w <= rd_data;
          state <= S_EDGE;
        end
        S_EDGE: begin
          if (cur_w[0]) begin
            edge_top <= 1'b0;
            cx <= x0; cy <= y0; dx <= x0; dy <= y0 + VW'(cell_size);
            ostep <= '0; ohalf <= 1'b0; state <= S_MUL;
          end else if (cur_w[1]) begin
            edge_top <= 1'b1;
            cx <= x0; cy <= y0 + VW'(cell_size);
            dx <= x0 + VW'(cell_size); dy <= y0 + VW'(cell_size);
            ostep <= '0; ohalf <= 1'b0; state <= S_MUL;
          end else begin
            state <= S_NEXT;
          end
        end
        S_MUL: begin
          // Product issued this cycle lands in prod next cycle.
          ohalf <= ~ohalf;
          if (ohalf) begin
            first_prod <= prod;
            state      <= S_EVAL;
          end
        end
        S_EVAL: begin
          osgn[ostep] <= {(first_prod < prod), (first_prod == prod)};
          if (ostep == 2'd3) begin
            state <= S_EVAL2;
          end else begin
            ostep <= ostep + 1'b1;
            state <= S_MUL;
          end
        end
        S_EVAL2: begin
          if (hit) begin
            can_see <= 1'b0;
            state   <= S_DONE;
          end else if (!edge_top && cur_w[1]) begin
            cur_w <= 2'b10;
            state <= S_EDGE;
          end else begin
            state <= S_NEXT;
          end
        end
        S_NEXT: begin
          addr <= addr + 1'b1;
          if (SW'(col) + 1'b1 >= side) begin
            col <= '0;
            x0  <= '0;
            y0  <= y0 + VW'(cell_size);
          end else begin
            col <= col + 1'b1;
            x0  <= x0 + VW'(cell_size);
          end
          state <= S_RD;
        end
        S_DONE: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- design/losw_checker.sv -----
// ----------------------------------------------------------------------------
// losw_checker
// Port-level checks for the line-of-sight wall check block.
// ----------------------------------------------------------------------------
module losw_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic kind,
  input logic done
);
  import losw_pkg::*;

  // A result follows only from a query that was running.
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("done without busy");

  // The block is idle in the cycle it shows a result.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("busy with done");

  // A transferred item always makes the block busy.
  a_take: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("item not taken");

  // A load transfer gives no result after its wall memory write.
  a_load: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && kind == KIND_LOAD) |=> ##1 !done) else $error("load result");

endmodule

bind line_of_sight_wall_check_core losw_checker u_losw_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind), .done(done)
);

// ----- test/line_of_sight_wall_check_core_tb.sv -----
// ----------------------------------------------------------------------------
// line_of_sight_wall_check_core_tb
// Self-checking bench: wall loads and line-of-sight queries are driven with
// random gaps. Each query's visibility is predicted from a private wall map
// with exact cross products, and compared with the strobed result.
// ----------------------------------------------------------------------------
module line_of_sight_wall_check_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import losw_pkg::*;

  localparam int MAX_SIDE = 16;
  localparam int CB = 14;
  localparam int IDLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic kind = KIND_LOAD;
  logic [7:0] cell_index = '0;
  logic [1:0] wall_code = '0;
  logic [CB-1:0] from_x = '0, from_y = '0, to_x = '0, to_y = '0;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_GRID_SIDE;
  logic [CELL_SIZE_BITS-1:0] cfg_data = '0;
  logic done;
  logic can_see;

  always #10 clk = ~clk;

  line_of_sight_wall_check_core #(.MAX_SIDE(MAX_SIDE), .COORD_BITS(CB)) i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind),
    .cell_index(cell_index), .wall_code(wall_code), .from_x(from_x),
    .from_y(from_y), .to_x(to_x), .to_y(to_y), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .done(done), .can_see(can_see)
  );

  // Predictor state.
  logic [1:0] walls [MAX_SIDE*MAX_SIDE];
  logic [GRID_SIDE_BITS-1:0] side_reg;
  logic [CELL_SIZE_BITS-1:0] size_reg;
  logic visible_q[$];
  int errors = 0;
  int idle_cycles = 0;
  int queries = 0, loads = 0, blocked = 0;

  function automatic int sgn(longint v);
    return int'(v > 0) - int'(v < 0);
  endfunction

  function automatic int turn(longint px, longint py, longint qx, longint qy,
                              longint rx, longint ry);
    return sgn((qx - px) * (ry - py) - (qy - py) * (rx - px));
  endfunction

  function automatic bit boxed(longint px, longint py, longint qx, longint qy,
                               longint rx, longint ry);
    return rx >= (px < qx ? px : qx) && rx <= (px > qx ? px : qx) &&
           ry >= (py < qy ? py : qy) && ry <= (py > qy ? py : qy);
  endfunction

  function automatic bit touches(longint ax, longint ay, longint bx, longint by,
                                 longint cx, longint cy, longint dx, longint dy);
    int o1, o2, o3, o4;
    o1 = turn(ax, ay, bx, by, cx, cy);
    o2 = turn(ax, ay, bx, by, dx, dy);
    o3 = turn(cx, cy, dx, dy, ax, ay);
    o4 = turn(cx, cy, dx, dy, bx, by);
    if (o1 * o2 < 0 && o3 * o4 < 0) return 1;
    if (o1 == 0 && boxed(ax, ay, bx, by, cx, cy)) return 1;
    if (o2 == 0 && boxed(ax, ay, bx, by, dx, dy)) return 1;
    if (o3 == 0 && boxed(cx, cy, dx, dy, ax, ay)) return 1;
    if (o4 == 0 && boxed(cx, cy, dx, dy, bx, by)) return 1;
    return 0;
  endfunction

  function automatic logic sight_clear(longint ax, longint ay, longint bx,
                                       longint by);
    int s;
    longint cs, x0, y0;
    s = (side_reg > MAX_SIDE) ? MAX_SIDE : side_reg;
    cs = size_reg;
    for (int i = 0; i < s * s; i++) begin
      x0 = (i % s) * cs;
      y0 = (i / s) * cs;
      if (walls[i][0] && touches(ax, ay, bx, by, x0, y0, x0, y0 + cs)) return 0;
      if (walls[i][1] && touches(ax, ay, bx, by, x0, y0 + cs, x0 + cs, y0 + cs))
        return 0;
    end
    return 1;
  endfunction

  // Result checking; done is sampled at the edge that ends its cycle.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (visible_q.size() == 0) begin
        $display("%0t: unexpected result can_see=%0d", $time, can_see);
        errors++;
      end else begin
        if (can_see !== visible_q[0]) begin
          $display("%0t: can_see mismatch expected %0d actual %0d", $time,
                   visible_q[0], can_see);
          errors++;
        end
        void'(visible_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("FAILURE");
      $finish;
    end
  end

  task automatic write_reg(logic idx, logic [CELL_SIZE_BITS-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_GRID_SIDE) side_reg = val[GRID_SIDE_BITS-1:0];
    else size_reg = val;
  endtask

  // Present one item, hold it until transferred, predict on transfer.
  // start stays high after a transfer; a gap or drain() lowers it.
  task automatic send_item(logic k, logic [7:0] idx, logic [1:0] wc,
                           logic [CB-1:0] ax, logic [CB-1:0] ay,
                           logic [CB-1:0] bx, logic [CB-1:0] by, int chk);
    logic vis;
    int gap;
    gap = $urandom_range(0, 4);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    kind <= k;
    cell_index <= idx;
    wall_code <= wc;
    from_x <= ax; from_y <= ay; to_x <= bx; to_y <= by;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (k == KIND_LOAD) begin
      walls[idx] = wc;
      loads++;
    end else begin
      vis = sight_clear(ax, ay, bx, by);
      if (chk >= 0 && vis !== chk[0]) begin
        $display("%0t: directed row expected %0d predicted %0d", $time, chk, vis);
        errors++;
      end
      visible_q.push_back(vis);
      queries++;
      if (!vis) blocked++;
    end
  endtask

  // Idle point between phases: all results in, plus load latency margin.
  task automatic drain();
    start <= 1'b0;
    while (visible_q.size() != 0 || busy) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  typedef struct {
    logic k; logic [7:0] idx; logic [1:0] wc;
    logic [CB-1:0] ax, ay, bx, by; int chk;
  } row_t;

  row_t rows[] = '{
    '{KIND_QUERY, 8'd0, 2'd0, 14'd0, 14'd0, 14'd16383, 14'd16383, 1},
    '{KIND_LOAD, 8'd0, 2'd1, 0, 0, 0, 0, -1},
    '{KIND_QUERY, 8'd0, 2'd0, 14'd0, 14'd8, 14'd0, 14'd8, 0},
    '{KIND_QUERY, 8'd0, 2'd0, 14'd0, 14'd16, 14'd0, 14'd40, 0},
    '{KIND_QUERY, 8'd0, 2'd0, 14'd1, 14'd0, 14'd1, 14'd40, 1},
    '{KIND_LOAD, 8'd255, 2'd2, 0, 0, 0, 0, -1},
    '{KIND_QUERY, 8'd0, 2'd0, 14'd250, 14'd250, 14'd250, 14'd16383, 0},
    '{KIND_QUERY, 8'd0, 2'd0, 14'd256, 14'd256, 14'd16383, 14'd16383, 0},
    '{KIND_QUERY, 8'd0, 2'd0, 14'd257, 14'd257, 14'd16383, 14'd16383, 1},
    '{KIND_QUERY, 8'd0, 2'd0, 14'd16383, 14'd0, 14'd0, 14'd16383, 1},
    '{KIND_LOAD, 8'd37, 2'd3, 0, 0, 0, 0, -1},
    '{KIND_QUERY, 8'd0, 2'd0, 14'd40, 14'd30, 14'd100, 14'd50, -1},
    '{KIND_QUERY, 8'd0, 2'd0, 14'd80, 14'd40, 14'd96, 14'd40, -1},
    '{KIND_LOAD, 8'd0, 2'd0, 0, 0, 0, 0, -1},
    '{KIND_LOAD, 8'd255, 2'd0, 0, 0, 0, 0, -1},
    '{KIND_LOAD, 8'd37, 2'd0, 0, 0, 0, 0, -1},
    '{KIND_QUERY, 8'd0, 2'd0, 14'd16383, 14'd16383, 14'd0, 14'd0, 1}
  };

  logic [CB-1:0] pa, pb, pc, pd;
  int lim, span;

  initial begin
    for (int i = 0; i < MAX_SIDE * MAX_SIDE; i++) walls[i] = '0;
    side_reg = GRID_SIDE_RESET;
    size_reg = CELL_SIZE_RESET;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (rows[r])
      send_item(rows[r].k, rows[r].idx, rows[r].wc, rows[r].ax, rows[r].ay,
                rows[r].bx, rows[r].by, rows[r].chk);
    drain();
    // Settings pass: extremes and middle values, including zero and oversize.
    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: begin write_reg(CFG_GRID_SIDE, 11'd1);  write_reg(CFG_CELL_SIZE, 11'd1024); end
        1: begin write_reg(CFG_GRID_SIDE, 11'd16); write_reg(CFG_CELL_SIZE, 11'd1); end
        2: begin write_reg(CFG_GRID_SIDE, 11'd4);  write_reg(CFG_CELL_SIZE, 11'd7); end
        3: begin write_reg(CFG_GRID_SIDE, 11'd0);  write_reg(CFG_CELL_SIZE, 11'd100); end
        4: begin write_reg(CFG_GRID_SIDE, 11'd31); write_reg(CFG_CELL_SIZE, 11'd2047); end
        5: begin write_reg(CFG_GRID_SIDE, 11'd8);  write_reg(CFG_CELL_SIZE, 11'd0); end
        6: begin write_reg(CFG_GRID_SIDE, 11'd3);  write_reg(CFG_CELL_SIZE, 11'd1365); end
        7: begin write_reg(CFG_GRID_SIDE, 11'd6);  write_reg(CFG_CELL_SIZE, 11'd682); end
        default: begin
          write_reg(CFG_GRID_SIDE, 11'($urandom_range(1, 16)));
          write_reg(CFG_CELL_SIZE, 11'($urandom_range(1, 1024)));
        end
      endcase
      span = ((side_reg > MAX_SIDE ? MAX_SIDE : side_reg) + 1) * size_reg;
      lim = (span < 16383 && span > 0) ? span : 16383;
      for (int n = 0; n < 100; n++) begin
        if ($urandom_range(0, 2) == 0) begin
          send_item(KIND_LOAD, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
                    CB'($urandom), CB'($urandom), CB'($urandom), CB'($urandom), -1);
        end else begin
          // Mostly points inside the maze, some on the cell lattice, some anywhere.
          case ($urandom_range(0, 3))
            0: begin
              pa = CB'($urandom); pb = CB'($urandom);
              pc = CB'($urandom); pd = CB'($urandom);
            end
            1: begin
              pa = CB'($urandom_range(0, 16) * size_reg);
              pb = CB'($urandom_range(0, lim));
              pc = pa; pd = CB'($urandom_range(0, lim));
            end
            default: begin
              pa = CB'($urandom_range(0, lim)); pb = CB'($urandom_range(0, lim));
              pc = CB'($urandom_range(0, lim)); pd = CB'($urandom_range(0, lim));
            end
          endcase
          send_item(KIND_QUERY, 8'($urandom), 2'($urandom), pa, pb, pc, pd, -1);
        end
      end
      drain();
    end
    $display("Covered %0d loads and %0d queries, %0d of them blocked.",
             loads, queries, blocked);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule
